// ===== sv/lgns_pkg.sv =====
// lgns_pkg: shared types, opcodes and constants of the layer gibbs node sampler
// used by every module of the block, no dependencies
`default_nettype none
package lgns_pkg;

    localparam int ROWS_DEF      = 512;
    localparam int COLS_DEF      = 512;
    localparam int MAX_LINES_DEF = 2;
    localparam int WGT_DEPTH     = 512;
    localparam int WGT_AW        = 9;
    localparam int Q_DEPTH       = 2;

    localparam logic [2:0] OP_PRIOR  = 3'd0;
    localparam logic [2:0] OP_WEIGHT = 3'd1;
    localparam logic [2:0] OP_LABEL  = 3'd2;
    localparam logic [2:0] OP_SAMPLE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] REG_THRESH  = 2'd0;
    localparam logic [1:0] REG_PENALTY = 2'd1;
    localparam logic [1:0] REG_NLINES  = 2'd2;

    typedef enum logic [2:0] {
        K_PRIOR  = 3'd0,
        K_WEIGHT = 3'd1,
        K_LABEL  = 3'd2,
        K_SAMPLE = 3'd3,
        K_READ   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        line;
        logic [8:0]  col;
        logic [8:0]  rowv;
        logic [15:0] data;
        logic        pin;
        logic [15:0] draw;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
    } t_bk_stat;

    typedef struct packed {
        logic [8:0]  thresh;
        logic [15:0] penalty;
        logic [1:0]  nl;
    } t_cfg;

endpackage
`default_nettype wire

// ===== sv/lgns_front.sv =====
// lgns_front: accepts input beats, drops ignored items, builds queue commands
// depends on lgns_pkg
`default_nettype none
module lgns_front import lgns_pkg::*; #(
    parameter int ROWS      = ROWS_DEF,
    parameter int COLS      = COLS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_opcode,
    input  wire logic        i_line_sel,
    input  wire logic [8:0]  i_column,
    input  wire logic [8:0]  i_row_value,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_pin_flag,
    input  wire logic [15:0] i_random_draw,
    input  wire logic [1:0]  i_nl,
    input  wire t_q_stat     i_qstat,
    input  wire t_bk_stat    i_bstat,
    output logic             o_stall,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic w_keep;
    logic w_col_ok;
    logic w_line_ok;
    logic w_row_ok;
    logic w_act_ok;

    always_comb begin
        w_col_ok  = 32'(i_column) < COLS;
        w_line_ok = 32'(i_line_sel) < MAX_LINES;
        w_row_ok  = 32'(i_row_value) < ROWS;
        w_act_ok  = {1'b0, i_line_sel} < i_nl;
        o_cmd.line = i_line_sel;
        o_cmd.col  = i_column;
        o_cmd.rowv = i_row_value;
        o_cmd.data = i_data_word;
        o_cmd.pin  = i_pin_flag;
        o_cmd.draw = i_random_draw;
        o_cmd.kind = K_WEIGHT;
        w_keep     = 1'b0;
        case (i_opcode)
            OP_WEIGHT: begin
                o_cmd.kind = K_WEIGHT;
                w_keep     = 1'b1;
            end
            OP_PRIOR: begin
                o_cmd.kind = K_PRIOR;
                w_keep     = w_col_ok && w_row_ok;
            end
            OP_LABEL: begin
                o_cmd.kind = K_LABEL;
                w_keep     = w_col_ok && w_line_ok;
                if (!w_row_ok) begin
                    o_cmd.rowv = 9'(ROWS - 1);
                end
            end
            OP_SAMPLE: begin
                o_cmd.kind = K_SAMPLE;
                w_keep     = w_col_ok && w_line_ok && w_act_ok;
            end
            OP_READ: begin
                o_cmd.kind = K_READ;
                w_keep     = w_col_ok && w_line_ok && w_act_ok;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
        o_stall = i_qstat.full || i_bstat.clearing;
        o_push  = i_valid && !o_stall && w_keep;
    end

endmodule
`default_nettype wire

// ===== sv/lgns_queue.sv =====
// lgns_queue: short command fifo between the front and the back
// depends on lgns_pkg
`default_nettype none
module lgns_queue import lgns_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

// ===== sv/lgns_back.sv =====
// lgns_back: executes queued commands, owns the prior, weight, label and scratch
// memories, runs the weighting and search passes; depends on lgns_pkg
`default_nettype none
module lgns_back import lgns_pkg::*; #(
    parameter int ROWS      = ROWS_DEF,
    parameter int COLS      = COLS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_head,
    input  wire t_q_stat i_qstat,
    output logic      o_pop,
    output t_bk_stat  o_stat,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output logic [8:0] o_label_row,
    output logic      o_line_out,
    output logic [8:0] o_column_out
);

    localparam int RW  = $clog2(ROWS);
    localparam int LW  = (RW > 9) ? RW : 9;
    localparam int LD  = MAX_LINES * COLS;
    localparam int LAW = $clog2(LD);
    localparam int PD  = ROWS * COLS;
    localparam int PAW = $clog2(PD);
    localparam int TW  = 32 + RW + 1;

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_LRD  = 10'b0000000100,
        S_LCAP = 10'b0000001000,
        S_WGT  = 10'b0000010000,
        S_TGT0 = 10'b0000100000,
        S_TGT1 = 10'b0001000000,
        S_SRCH = 10'b0010000000,
        S_WB   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_st, n_st;

    logic [15:0] r_prior [PD];
    logic [15:0] r_wgt   [WGT_DEPTH];
    logic [LW:0] r_lbl   [LD];
    logic [31:0] r_scr   [ROWS];

    t_cmd           r_cmd;
    logic [LAW-1:0] r_clr_cnt;
    logic [1:0]     r_ls;
    logic [LW:0]    r_self;
    logic [LW-1:0]  r_oth;
    logic [LW-1:0]  r_nr;
    logic [LW-1:0]  r_nlft;
    logic [LW:0]    r_lq;
    logic [RW-1:0]  r_m;
    logic           r_iss;
    logic [15:0]    r_pq;
    logic [15:0]    r_wrq;
    logic [15:0]    r_wlq;
    logic           r_v1, r_v2, r_v3, r_v4;
    logic [RW-1:0]  r_i1, r_i2, r_i3, r_i4;
    logic           r_vf1;
    logic [31:0]    r_s2, r_s3, r_s4;
    logic [15:0]    r_wr2, r_wl2, r_wl3;
    logic [TW-1:0]  r_total;
    logic [47:0]    r_plo;
    logic [TW-17:0] r_phi;
    logic [TW-1:0]  r_tgt;
    logic [TW-1:0]  r_run;
    logic [31:0]    r_sq;
    logic           r_sv;
    logic [RW-1:0]  r_sidx;
    logic [LW-1:0]  r_res;
    logic           r_out_vld;
    logic [8:0]     r_out_lbl;
    logic           r_out_line;
    logic [8:0]     r_out_col;

    logic           w_hr_en, w_hl_en, w_below, w_above, w_vert_en;
    logic [LAW-1:0] w_self_a, w_head_a, w_lrd_a, w_lwa;
    logic           w_lwe;
    logic [LW:0]    w_lwd;
    logic [PAW-1:0] w_pwa, w_pra;
    logic [LW-1:0]  w_mx, w_dr, w_dl;
    logic [WGT_AW-1:0] w_ar, w_al;
    logic signed [LW+1:0] w_diff;
    logic           w_vf;
    logic [47:0]    w_p2, w_p3;
    logic [TW+15:0] w_prod;
    logic [TW-1:0]  w_sum;
    logic           w_load;
    logic           w_pipe_busy;

    always_comb begin
        w_hr_en   = (32'(r_cmd.col) + 1) < COLS;
        w_hl_en   = (r_cmd.col != '0);
        w_below   = (32'(r_cmd.line) + 1) < 32'(i_cfg.nl);
        w_above   = r_cmd.line;
        w_vert_en = w_below || w_above;
        w_self_a  = LAW'(32'(r_cmd.line) * COLS + 32'(r_cmd.col));
        w_head_a  = LAW'(32'(i_head.line) * COLS + 32'(i_head.col));
        case (r_ls)
            2'd1:    w_lrd_a = w_vert_en ?
                         LAW'(32'(!r_cmd.line) * COLS + 32'(r_cmd.col)) : w_self_a;
            2'd2:    w_lrd_a = w_hr_en ? w_self_a + 1'b1 : w_self_a;
            2'd3:    w_lrd_a = w_hl_en ? w_self_a - 1'b1 : w_self_a;
            default: w_lrd_a = w_self_a;
        endcase
        o_pop = (r_st == S_IDLE) && !i_qstat.empty;
        w_lwe = 1'b0;
        w_lwa = w_self_a;
        w_lwd = {1'b0, r_res};
        if (r_st == S_CLR) begin
            w_lwe = 1'b1;
            w_lwa = r_clr_cnt;
            w_lwd = '0;
        end else if (o_pop && i_head.kind == K_LABEL) begin
            w_lwe = 1'b1;
            w_lwa = w_head_a;
            w_lwd = {i_head.pin, LW'(i_head.rowv)};
        end else if (r_st == S_WB) begin
            w_lwe = 1'b1;
        end
        w_pwa = PAW'(32'(i_head.col) * ROWS + 32'(i_head.rowv));
        w_pra = PAW'(32'(r_cmd.col) * ROWS + 32'(r_m));
        w_mx  = LW'(r_m);
        w_dr  = (w_mx > r_nr) ? w_mx - r_nr : r_nr - w_mx;
        w_dl  = (w_mx > r_nlft) ? w_mx - r_nlft : r_nlft - w_mx;
        w_ar  = (32'(w_dr) > WGT_DEPTH - 1) ? WGT_AW'(WGT_DEPTH - 1) : WGT_AW'(w_dr);
        w_al  = (32'(w_dl) > WGT_DEPTH - 1) ? WGT_AW'(WGT_DEPTH - 1) : WGT_AW'(w_dl);
        if (w_below) begin
            w_diff = $signed({2'b00, r_oth}) - $signed({2'b00, w_mx});
        end else begin
            w_diff = $signed({2'b00, w_mx}) - $signed({2'b00, r_oth});
        end
        w_vf   = w_vert_en && (w_diff < $signed({2'b00, (LW)'(i_cfg.thresh)}));
        w_p2   = 48'(r_s2) * 48'(r_wr2);
        w_p3   = 48'(r_s3) * 48'(r_wl3);
        w_prod = {r_phi, 32'd0} + (TW+16)'(r_plo);
        w_sum  = r_run + TW'(r_sq);
        w_load = (r_st == S_OUT) && (!r_out_vld || !i_out_stall);
        w_pipe_busy = r_iss || r_v1 || r_v2 || r_v3 || r_v4;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLR:  if (r_clr_cnt == LAW'(LD - 1)) n_st = S_IDLE;
            S_IDLE: begin
                if (o_pop && (i_head.kind == K_SAMPLE || i_head.kind == K_READ)) begin
                    n_st = S_LRD;
                end
            end
            S_LRD:  n_st = S_LCAP;
            S_LCAP: begin
                if (r_ls != 2'd3) begin
                    n_st = S_LRD;
                end else if (r_cmd.kind == K_READ || r_self[LW]) begin
                    n_st = S_OUT;
                end else begin
                    n_st = S_WGT;
                end
            end
            S_WGT:  if (!w_pipe_busy) n_st = S_TGT0;
            S_TGT0: n_st = S_TGT1;
            S_TGT1: n_st = S_SRCH;
            S_SRCH: begin
                if (r_sv && (w_sum >= r_tgt || r_sidx == RW'(ROWS - 1))) n_st = S_WB;
            end
            S_WB:   n_st = S_OUT;
            S_OUT:  if (w_load) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_CLR;
            r_clr_cnt <= '0;
            r_iss     <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_sv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            r_v1 <= (r_st == S_WGT) && r_iss;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_sv <= (r_st == S_SRCH) && r_iss;
            if (r_st == S_LCAP && r_ls == 2'd3) begin
                r_iss <= 1'b1;
            end else if (r_st == S_TGT1) begin
                r_iss <= 1'b1;
            end else if ((r_st == S_WGT || r_st == S_SRCH) && r_iss
                         && r_m == RW'(ROWS - 1)) begin
                r_iss <= 1'b0;
            end else if (r_st == S_SRCH && n_st == S_WB) begin
                r_iss <= 1'b0;
            end
            r_out_vld <= w_load || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
            r_ls  <= 2'd0;
        end
        if (r_st == S_LCAP) begin
            r_ls <= r_ls + 1'b1;
            case (r_ls)
                2'd0:    r_self <= r_lq;
                2'd1:    r_oth  <= r_lq[LW-1:0];
                2'd2:    r_nr   <= r_lq[LW-1:0];
                default: r_nlft <= r_lq[LW-1:0];
            endcase
            if (r_ls == 2'd3) begin
                r_m     <= '0;
                r_total <= '0;
                r_res   <= r_self[LW-1:0];
            end
        end
        if ((r_st == S_WGT || r_st == S_SRCH) && r_iss && r_m != RW'(ROWS - 1)) begin
            r_m <= r_m + 1'b1;
        end
        r_i1  <= r_m;
        r_vf1 <= w_vf;
        r_s2  <= r_vf1 ? 32'(r_pq) * 32'(i_cfg.penalty) : {r_pq, 16'h0000};
        r_wr2 <= r_wrq;
        r_wl2 <= r_wlq;
        r_i2  <= r_i1;
        r_s3  <= w_hr_en ? w_p2[47:16] : r_s2;
        r_wl3 <= r_wl2;
        r_i3  <= r_i2;
        r_s4  <= w_hl_en ? w_p3[47:16] : r_s3;
        r_i4  <= r_i3;
        if (r_v4) begin
            r_total <= r_total + TW'(r_s4);
        end
        if (r_st == S_TGT0) begin
            r_plo <= 48'(r_total[31:0]) * 48'(r_cmd.draw);
            r_phi <= (TW-16)'(r_total[TW-1:32]) * (TW-16)'(r_cmd.draw);
        end
        if (r_st == S_TGT1) begin
            r_tgt <= w_prod[TW+15:16];
            r_m   <= '0;
            r_run <= '0;
        end
        r_sidx <= r_m;
        if (r_st == S_SRCH && r_sv) begin
            r_run <= w_sum;
            r_res <= LW'(r_sidx);
        end
        if (w_load) begin
            r_out_lbl  <= 9'(r_res);
            r_out_line <= r_cmd.line;
            r_out_col  <= r_cmd.col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == K_PRIOR) begin
            r_prior[w_pwa] <= i_head.data;
        end
        r_pq <= r_prior[w_pra];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == K_WEIGHT) begin
            r_wgt[i_head.rowv] <= i_head.data;
        end
        r_wrq <= r_wgt[w_ar];
        r_wlq <= r_wgt[w_al];
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            r_lbl[w_lwa] <= w_lwd;
        end
        r_lq <= r_lbl[w_lrd_a];
    end

    always_ff @(posedge i_clk) begin
        if (r_v4) begin
            r_scr[r_i4] <= r_s4;
        end
        r_sq <= r_scr[r_m];
    end

    assign o_stat.clearing = (r_st == S_CLR);
    assign o_out_valid     = r_out_vld;
    assign o_label_row     = r_out_lbl;
    assign o_line_out      = r_out_line;
    assign o_column_out    = r_out_col;

endmodule
`default_nettype wire

// ===== sv/layer_gibbs_node_sampler_core.sv =====
// Layer gibbs node sampler. Load items (prior, weight, set label) retire one per
// cycle from a two-entry command queue while the back end is idle. A read label
// item goes through the label memory reads and then to the output register. A
// sample item of an unpinned node runs four label memory reads, a weighting pass
// that streams one row per cycle through the prior memory and three registered
// multipliers, the draw target computation, and a cumulative search pass that
// reads the scratch memory one row per cycle and stops at the first hit or at the
// last row. After reset a clearing pass sweeps every entry of the label memory;
// items are stalled until it ends, configuration writes are taken throughout.
// depends on lgns_pkg, lgns_front, lgns_queue, lgns_back
`default_nettype none
module layer_gibbs_node_sampler_core import lgns_pkg::*; #(
    parameter int ROWS      = ROWS_DEF,
    parameter int COLS      = COLS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic        i_line_sel,
    input  wire logic [8:0]  i_column,
    input  wire logic [8:0]  i_row_value,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_pin_flag,
    input  wire logic [15:0] i_random_draw,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [8:0]       o_label_row,
    output logic             o_line_out,
    output logic [8:0]       o_column_out
);

    logic [8:0]  r_thresh;
    logic [15:0] r_penalty;
    logic [1:0]  r_nlines;
    logic        w_wr;
    t_cfg        w_cfg;
    t_cmd        w_push_cmd;
    t_cmd        w_head;
    logic        w_push;
    logic        w_pop;
    t_q_stat     w_qstat;
    t_bk_stat    w_bstat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= 9'd25;
            r_penalty <= 16'd6554;
            r_nlines  <= 2'd2;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_THRESH:  r_thresh  <= pwdata[8:0];
                REG_PENALTY: r_penalty <= pwdata[15:0];
                REG_NLINES:  r_nlines  <= pwdata[1:0];
                default:     r_thresh  <= r_thresh;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THRESH:  prdata = {23'd0, r_thresh};
            REG_PENALTY: prdata = {16'd0, r_penalty};
            REG_NLINES:  prdata = {30'd0, r_nlines};
            default:     prdata = '0;
        endcase
        w_cfg.thresh  = r_thresh;
        w_cfg.penalty = r_penalty;
        if (r_nlines == 2'd0) begin
            w_cfg.nl = 2'd1;
        end else if (32'(r_nlines) > MAX_LINES) begin
            w_cfg.nl = 2'(MAX_LINES);
        end else begin
            w_cfg.nl = r_nlines;
        end
    end

    lgns_front #(.ROWS(ROWS), .COLS(COLS), .MAX_LINES(MAX_LINES)) u_front (
        .i_valid       (i_in_valid),
        .i_opcode      (i_opcode),
        .i_line_sel    (i_line_sel),
        .i_column      (i_column),
        .i_row_value   (i_row_value),
        .i_data_word   (i_data_word),
        .i_pin_flag    (i_pin_flag),
        .i_random_draw (i_random_draw),
        .i_nl          (w_cfg.nl),
        .i_qstat       (w_qstat),
        .i_bstat       (w_bstat),
        .o_stall       (o_in_stall),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    lgns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    lgns_back #(.ROWS(ROWS), .COLS(COLS), .MAX_LINES(MAX_LINES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head       (w_head),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .o_stat       (w_bstat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_label_row  (o_label_row),
        .o_line_out   (o_line_out),
        .o_column_out (o_column_out)
    );

`ifndef SYNTHESIS
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.clearing |-> o_in_stall)
        else $error("item accepted during label clearing pass");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> (o_in_stall && !w_push))
        else $error("push into full command queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty command queue");

    a_out_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_line_out) < MAX_LINES))
        else $error("result reports a line beyond the line count");
`endif

endmodule
`default_nettype wire

// ===== sim/lgns_checker.sv =====
// lgns_checker: watches the item, result and register channels of the node sampler,
// predicts every result from its own copy of the stores and compares in order
// depends on lgns_pkg
`timescale 1ns / 1ps
module lgns_checker import lgns_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic        i_line_sel,
    input  wire logic [8:0]  i_column,
    input  wire logic [8:0]  i_row_value,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_pin_flag,
    input  wire logic [15:0] i_random_draw,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [8:0]  i_label_row,
    input  wire logic        i_line_out,
    input  wire logic [8:0]  i_column_out,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_samples,
    output int               o_reads
);

    typedef struct packed {
        logic [8:0] row;
        logic       line;
        logic [8:0] col;
    } t_node_report;

    logic [15:0] prior_mem [0:ROWS_DEF*COLS_DEF-1];
    logic [15:0] wgt_mem [0:WGT_DEPTH-1];
    logic [8:0]  label_mem [0:MAX_LINES_DEF*COLS_DEF-1];
    logic        pin_mem [0:MAX_LINES_DEF*COLS_DEF-1];
    logic [8:0]  thresh;
    logic [15:0] penalty;
    logic [1:0]  nlines;
    t_node_report expected_reports [$];

    function automatic logic [31:0] scale_q16(input logic [31:0] w, input logic [15:0] f);
        logic [63:0] p;
        p = 64'(w) * 64'(f);
        return p[47:16];
    endfunction

    function automatic int lines_active();
        if (nlines == 2'd0) return 1;
        if (nlines > 2'd2) return 2;
        return int'(nlines);
    endfunction

    function automatic logic [8:0] resample_row(input logic ln, input logic [8:0] col,
                                                input logic [15:0] rnd);
        logic [31:0] w [0:ROWS_DEF-1];
        logic [63:0] total;
        logic [63:0] target;
        logic [63:0] run;
        int m;
        int diff;
        int d;
        int base;
        base = ln ? COLS_DEF : 0;
        if (pin_mem[base + col]) return label_mem[base + col];
        total = 0;
        for (m = 0; m < ROWS_DEF; m++) begin
            w[m] = {prior_mem[col*ROWS_DEF + m], 16'h0000};
            if (!ln && lines_active() > 1) begin
                diff = int'(label_mem[COLS_DEF + col]) - m;
                if (diff < int'(thresh)) w[m] = scale_q16(w[m], penalty);
            end
            if (ln) begin
                diff = m - int'(label_mem[col]);
                if (diff < int'(thresh)) w[m] = scale_q16(w[m], penalty);
            end
            if (col < COLS_DEF - 1) begin
                d = m - int'(label_mem[base + col + 1]);
                if (d < 0) d = -d;
                w[m] = scale_q16(w[m], wgt_mem[d]);
            end
            if (col > 0) begin
                d = m - int'(label_mem[base + col - 1]);
                if (d < 0) d = -d;
                w[m] = scale_q16(w[m], wgt_mem[d]);
            end
            total += 64'(w[m]);
        end
        target = (total * 64'(rnd)) >> 16;
        run = 0;
        for (m = 0; m < ROWS_DEF; m++) begin
            run += 64'(w[m]);
            if (run >= target) return 9'(m);
        end
        return 9'(ROWS_DEF - 1);
    endfunction

    task automatic report_fail(input string what, input t_node_report exp_r,
                               input t_node_report got_r);
        if (o_fail_count < 10)
            $display("mismatch %s: expected row %0d line %0d col %0d, got row %0d line %0d col %0d",
                     what, exp_r.row, exp_r.line, exp_r.col, got_r.row, got_r.line, got_r.col);
        o_fail_count++;
    endtask

    assign o_pending = expected_reports.size();

    initial begin
        o_fail_count = 0;
        o_samples = 0;
        o_reads = 0;
    end

    always @(posedge i_clk) begin
        t_node_report got_r;
        t_node_report exp_r;
        int idx;
        if (!i_rst_n) begin
            thresh <= 9'd25;
            penalty <= 16'd6554;
            nlines <= 2'd2;
            for (idx = 0; idx < MAX_LINES_DEF*COLS_DEF; idx++) pin_mem[idx] = 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_THRESH:  thresh <= i_pwdata[8:0];
                    REG_PENALTY: penalty <= i_pwdata[15:0];
                    REG_NLINES:  nlines <= i_pwdata[1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got_r = '{row: i_label_row, line: i_line_out, col: i_column_out};
                if (expected_reports.size() == 0) begin
                    report_fail("unexpected beat", '0, got_r);
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (exp_r !== got_r) report_fail("result beat", exp_r, got_r);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                idx = (i_line_sel ? COLS_DEF : 0) + int'(i_column);
                case (i_opcode)
                    OP_PRIOR:  prior_mem[int'(i_column)*ROWS_DEF + int'(i_row_value)] = i_data_word;
                    OP_WEIGHT: wgt_mem[i_row_value] = i_data_word;
                    OP_LABEL: begin
                        label_mem[idx] = i_row_value;
                        pin_mem[idx] = i_pin_flag;
                    end
                    OP_SAMPLE, OP_READ: begin
                        if (int'(i_line_sel) < lines_active()) begin
                            if (i_opcode == OP_SAMPLE) begin
                                label_mem[idx] = resample_row(i_line_sel, i_column,
                                                              i_random_draw);
                                o_samples++;
                            end else begin
                                o_reads++;
                            end
                            exp_r = '{row: label_mem[idx], line: i_line_sel, col: i_column};
                            expected_reports.insert(expected_reports.size(), exp_r);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
// tb: top of the node sampler testbench, drives reset, register writes and item beats
// with random idling, and gives the verdict; depends on lgns_pkg, lgns_checker and the core
`timescale 1ns / 1ps
module tb;
    import lgns_pkg::*;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int DRAIN_CYCLES = 1200;
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic        i_line_sel;
    logic [8:0]  i_column;
    logic [8:0]  i_row_value;
    logic [15:0] i_data_word;
    logic        i_pin_flag;
    logic [15:0] i_random_draw;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [8:0]  o_label_row;
    logic        o_line_out;
    logic [8:0]  o_column_out;

    int fail_count;
    int pending;
    int samples;
    int reads;
    int cycles;
    int send_idle;
    int recv_idle;
    int hold_left;

    int samp_cols [5] = '{0, 1, 255, 510, 511};
    int lab_cols [9] = '{0, 1, 2, 254, 255, 256, 509, 510, 511};
    logic [8:0]  ph_thresh [4] = '{9'd0, 9'd511, 9'd60, 9'd25};
    logic [15:0] ph_penalty [4] = '{16'd65535, 16'd0, 16'd30000, 16'd6554};
    logic [1:0]  ph_nlines [4] = '{2'd0, 2'd3, 2'd1, 2'd2};
    int ph_send_idle [4] = '{37, 80, 0, 0};
    int ph_recv_idle [4] = '{80, 37, 0, 0};

    layer_gibbs_node_sampler_core dut (.*);

    lgns_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_opcode(i_opcode),
        .i_line_sel(i_line_sel), .i_column(i_column), .i_row_value(i_row_value),
        .i_data_word(i_data_word), .i_pin_flag(i_pin_flag), .i_random_draw(i_random_draw),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_label_row(o_label_row),
        .i_line_out(o_line_out), .i_column_out(o_column_out),
        .o_fail_count(fail_count), .o_pending(pending), .o_samples(samples), .o_reads(reads)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_beat(input logic [2:0] op, input logic ln, input logic [8:0] col,
                             input logic [8:0] row, input logic [15:0] data,
                             input logic pin, input logic [15:0] rnd);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_line_sel <= ln;
        i_column <= col;
        i_row_value <= row;
        i_data_word <= data;
        i_pin_flag <= pin;
        i_random_draw <= rnd;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_beat();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            send_beat(OP_SAMPLE, 1'($urandom), 9'(samp_cols[$urandom_range(4)]),
                      9'($urandom), 16'($urandom), 1'($urandom), pick_word());
        else if (sel < 55)
            send_beat(OP_READ, 1'($urandom), 9'(lab_cols[$urandom_range(8)]),
                      9'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
        else if (sel < 67)
            send_beat(OP_LABEL, 1'($urandom), 9'(lab_cols[$urandom_range(8)]),
                      9'($urandom), 16'($urandom), ($urandom_range(3) == 0), 16'($urandom));
        else if (sel < 79)
            send_beat(OP_WEIGHT, 1'($urandom), 9'($urandom), 9'($urandom), pick_word(),
                      1'($urandom), 16'($urandom));
        else if (sel < 94)
            send_beat(OP_PRIOR, 1'($urandom), 9'($urandom), 9'($urandom), pick_word(),
                      1'($urandom), 16'($urandom));
        else
            send_beat(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 1'($urandom),
                      9'($urandom), 9'($urandom), 16'($urandom), 1'($urandom),
                      16'($urandom));
    endtask

    initial begin
        int ph;
        int n;
        int k;
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_PRIOR;
        i_line_sel = 1'b0;
        i_column = '0;
        i_row_value = '0;
        i_data_word = '0;
        i_pin_flag = 1'b0;
        i_random_draw = '0;
        i_out_stall = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // preload weights, labels around the sampled columns, and their priors
        send_beat(OP_WEIGHT, 1'b0, '0, 9'd0, 16'hFFFF, 1'b0, '0);
        send_beat(OP_WEIGHT, 1'b1, '0, 9'd511, 16'h0000, 1'b0, '0);
        for (n = 1; n < WGT_DEPTH - 1; n++)
            send_beat(OP_WEIGHT, 1'($urandom), '0, 9'(n), 16'(65535 - n * 100), 1'b0, '0);
        for (k = 0; k < 9; k++) begin
            send_beat(OP_LABEL, 1'b0, 9'(lab_cols[k]), 9'($urandom_range(100, 300)),
                      16'($urandom), 1'b0, '0);
            send_beat(OP_LABEL, 1'b1, 9'(lab_cols[k]), 9'($urandom_range(200, 450)),
                      16'($urandom), 1'b0, '0);
        end
        for (k = 0; k < 5; k++)
            for (n = 0; n < ROWS_DEF; n++)
                send_beat(OP_PRIOR, 1'($urandom), 9'(samp_cols[k]), 9'(n),
                          (k == 3 && n > 3) ? 16'h0000 : pick_word(), 1'($urandom), '0);

        // directed: edges, draw extremes, pinned node, crossed lines, spare opcodes
        send_beat(OP_READ, 1'b0, 9'd0, '0, '0, 1'b0, '0);
        send_beat(OP_READ, 1'b1, 9'd511, 9'h1FF, 16'hFFFF, 1'b1, 16'hFFFF);
        send_beat(OP_SAMPLE, 1'b0, 9'd0, '0, '0, 1'b0, 16'h0000);
        send_beat(OP_SAMPLE, 1'b1, 9'd511, '0, '0, 1'b0, 16'hFFFF);
        send_beat(OP_SAMPLE, 1'b0, 9'd510, '0, '0, 1'b0, 16'h8000);
        send_beat(OP_LABEL, 1'b0, 9'd255, 9'd300, '0, 1'b1, '0);
        send_beat(OP_SAMPLE, 1'b0, 9'd255, '0, '0, 1'b0, 16'h1234);
        send_beat(OP_READ, 1'b0, 9'd255, '0, '0, 1'b0, '0);
        send_beat(OP_LABEL, 1'b0, 9'd1, 9'd400, '0, 1'b0, '0);
        send_beat(OP_LABEL, 1'b1, 9'd1, 9'd100, '0, 1'b0, '0);
        send_beat(OP_SAMPLE, 1'b0, 9'd1, '0, '0, 1'b0, 16'h4000);
        send_beat(OP_SAMPLE, 1'b1, 9'd1, '0, '0, 1'b0, 16'hC000);
        send_beat(OP_LABEL, 1'b1, 9'd511, 9'h1FF, '0, 1'b0, '0);
        send_beat(OP_SAMPLE, 1'b1, 9'd511, '0, '0, 1'b0, 16'h0001);
        send_beat(OP_SPARE_LO, 1'b0, 9'd0, '0, '0, 1'b0, '0);
        send_beat(OP_SPARE_MID, 1'b1, 9'h1FF, 9'h1FF, 16'hFFFF, 1'b1, 16'hFFFF);
        send_beat(OP_SPARE_HI, 1'b0, 9'd1, '0, '0, 1'b0, '0);
        send_beat(OP_READ, 1'b1, 9'd1, '0, '0, 1'b0, '0);

        for (ph = 0; ph < 4; ph++) begin
            wait_idle();
            reg_write(REG_THRESH, 32'(ph_thresh[ph]));
            reg_write(REG_PENALTY, 32'(ph_penalty[ph]));
            reg_write(REG_NLINES, 32'(ph_nlines[ph]));
            send_idle = ph_send_idle[ph];
            recv_idle = ph_recv_idle[ph];
            if (ph == 0) hold_left = 3000;
            for (n = 0; n < 135; n++) begin
                if (ph == 2 && n == 60) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    wait (pending == 0);
                end
                random_beat();
            end
        end

        wait_idle();
        $display("covered %0d samples and %0d label reads over four register settings",
                 samples, reads);
        $display("with random idling on both channels and a long result hold-off");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
